[hdl/srra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srra_pkg
// Shared types, constants and helpers of the stub region round-robin assigner.
// ----------------------------------------------------------------------------
package srra_pkg;

  // default sizes
  localparam int MAX_PER_REGION_DEF = 256;
  localparam int MAX_REGIONS_DEF    = 9;

  // field widths
  localparam int ID_W   = 12;
  localparam int BEND_W = 5;
  localparam int SEC_W  = 10;
  localparam int CFG_W  = 7;
  localparam int DIV_W  = 11;   // dividend / quotient width of the shared divider
  localparam int DSR_W  = 7;    // divisor / remainder width

  // register reset values
  localparam logic [3:0] NUM_REGIONS_RST = 4'd9;
  localparam logic [6:0] SPR_RST         = 7'd2;
  localparam logic [6:0] LPR_RST         = 7'd24;
  localparam logic       OBB_RST         = 1'b1;

  // register indexes
  typedef enum logic [1:0] {
    REG_NUM_REGIONS = 2'd0,
    REG_SPR         = 2'd1,
    REG_LPR         = 2'd2,
    REG_ORDER_BEND  = 2'd3
  } reg_idx_t;

  // commands
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_DRAIN  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_DIV1,
    ST_LD_DIV2,
    ST_LD_ST1,
    ST_LD_ST2,
    ST_SO_I,
    ST_SO_LD,
    ST_SO_CMP,
    ST_SO_PUT,
    ST_DR_SCAN,
    ST_DR_WAIT
  } state_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] quot;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

  // magnitude of a 5-bit two's complement bend
  function automatic logic [BEND_W-1:0] abs_bend(input logic [BEND_W-1:0] b);
    abs_bend = b[BEND_W-1] ? (~b + 5'd1) : b;
  endfunction

endpackage

[hdl/stub_region_round_robin_assigner_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stub_region_round_robin_assigner_core
// Buffers stubs per phi region and hands them out as round-robin link slots.
// ----------------------------------------------------------------------------
// Items are processed one at a time. An accepted load runs two passes of the
// shared bit-serial divider (sector / sectors_per_region), one for the first
// and one for the last sector, then up to two writes into the stub memory.
// A drain skips empty regions, then does one memory read and one divider pass
// for index / links_per_region. The first drain of an event, with bend
// ordering on, first runs an in-memory insertion sort of every region through
// the single read and single write port of the memory. Clear, cmd 3 and
// ignored loads are handled in the idle state. No clearing pass follows reset:
// only entries below a region's fill are ever read.
module stub_region_round_robin_assigner_core #(
  parameter int MAX_PER_REGION = srra_pkg::MAX_PER_REGION_DEF,
  parameter int MAX_REGIONS    = srra_pkg::MAX_REGIONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [srra_pkg::CFG_W-1:0] cfg_data,
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [39:0]                s_tdata,  // stub_id, pass_flag, first_sector, last_sector, bend_half
  input  logic [1:0]                 s_tuser,  // cmd
  // output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [39:0]                m_tdata,  // out_stub, out_region, out_link, out_position
  output logic                       m_tlast,  // out_last
  output logic                       m_tuser   // overflow
);

  localparam int RW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int RCW   = $clog2(MAX_REGIONS + 1);
  localparam int IDXW  = $clog2(MAX_PER_REGION);
  localparam int FW    = $clog2(MAX_PER_REGION + 1);
  localparam int DEPTH = MAX_REGIONS * MAX_PER_REGION;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = srra_pkg::ID_W + srra_pkg::BEND_W;

  // configuration registers
  logic [3:0] num_regions;
  logic [6:0] spr;
  logic [6:0] lpr;
  logic       order_bend;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_regions <= srra_pkg::NUM_REGIONS_RST;
      spr         <= srra_pkg::SPR_RST;
      lpr         <= srra_pkg::LPR_RST;
      order_bend  <= srra_pkg::OBB_RST;
    end else if (cfg_we) begin
      case (srra_pkg::reg_idx_t'(cfg_index))
        srra_pkg::REG_NUM_REGIONS: num_regions <= cfg_data[3:0];
        srra_pkg::REG_SPR:         spr         <= cfg_data;
        srra_pkg::REG_LPR:         lpr         <= cfg_data;
        srra_pkg::REG_ORDER_BEND:  order_bend  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [6:0]     spr_eff;
  logic [6:0]     lpr_eff;
  logic [RCW-1:0] nreg;

  assign spr_eff = (spr == '0) ? 7'd1 : spr;
  assign lpr_eff = (lpr == '0) ? 7'd1 : lpr;
  assign nreg    = ({1'b0, num_regions} < 5'(MAX_REGIONS)) ? RCW'(num_regions)
                                                         : RCW'(MAX_REGIONS);

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r,
                                            input logic [IDXW-1:0] i);
    addr_of = AW'(r) * AW'(MAX_PER_REGION) + AW'(i);
  endfunction

  // input fields
  srra_pkg::cmd_t               in_cmd;
  logic [srra_pkg::ID_W-1:0]    in_id;
  logic                         in_pass;
  logic [srra_pkg::SEC_W-1:0]   in_first;
  logic [srra_pkg::SEC_W-1:0]   in_last;
  logic [srra_pkg::BEND_W-1:0]  in_bend;

  assign in_cmd   = srra_pkg::cmd_t'(s_tuser);
  assign in_id    = s_tdata[11:0];
  assign in_pass  = s_tdata[12];
  assign in_first = s_tdata[22:13];
  assign in_last  = s_tdata[32:23];
  assign in_bend  = s_tdata[37:33];

  // state
  srra_pkg::state_t state, state_next;
  logic [FW-1:0]    fill [MAX_REGIONS];
  logic [RCW-1:0]   dreg;
  logic [FW-1:0]    didx;
  logic             sorted_done;
  logic             overflow_seen;

  // latched load item
  logic [srra_pkg::ID_W-1:0]   ld_id;
  logic [srra_pkg::BEND_W-1:0] ld_bend;
  logic [srra_pkg::SEC_W-1:0]  ld_last;
  logic [srra_pkg::DIV_W-1:0]  r1q;

  // sort pointers
  logic [RCW-1:0] sreg;
  logic [FW-1:0]  si;
  logic [FW-1:0]  sj;
  logic [DW-1:0]  hold;
  logic           drain_last;

  // memory and divider
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [DW-1:0]   ram_wdata, ram_rdata;
  srra_pkg::div_req_t div_req;
  srra_pkg::div_rsp_t div_rsp;

  srra_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  srra_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // store target for load states
  logic [srra_pkg::DIV_W-1:0] st_reg;
  logic                       st_want;
  logic                       st_in_range;
  logic [RW-1:0]              st_r;
  logic                       st_full;

  assign st_reg      = (state == srra_pkg::ST_LD_ST1) ? r1q : div_rsp.quot;
  assign st_want     = (state == srra_pkg::ST_LD_ST1) ||
                       ((state == srra_pkg::ST_LD_ST2) && (div_rsp.quot != r1q));
  assign st_in_range = (st_reg < srra_pkg::DIV_W'(nreg));
  assign st_r        = st_reg[RW-1:0];
  assign st_full     = st_in_range && (fill[st_r] == FW'(MAX_PER_REGION));

  // sort and drain helpers
  logic [RW-1:0] sreg_r, dreg_r;
  logic          sreg_ok, dreg_ok;
  logic          moves;
  logic          later_any;

  assign sreg_r  = sreg[RW-1:0];
  assign dreg_r  = dreg[RW-1:0];
  assign sreg_ok = (sreg < nreg);
  assign dreg_ok = (dreg < nreg);
  assign moves   = srra_pkg::abs_bend(ram_rdata[srra_pkg::BEND_W-1:0]) >
                   srra_pkg::abs_bend(hold[srra_pkg::BEND_W-1:0]);

  // any later region still holding stubs
  always_comb begin
    later_any = 1'b0;
    for (int k = 0; k < MAX_REGIONS; k++) begin
      if ((RCW'(k) > dreg) && (RCW'(k) < nreg) && (fill[k] != '0)) begin
        later_any = 1'b1;
      end
    end
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == srra_pkg::ST_IDLE);

  // next state and memory / divider control
  always_comb begin
    state_next       = state;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = '0;
    ram_re           = 1'b0;
    ram_raddr        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = spr_eff;
    case (state)
      srra_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (in_cmd)
            srra_pkg::CMD_LOAD: begin
              if (in_pass && !sorted_done) begin
                div_req.start    = 1'b1;
                div_req.dividend = srra_pkg::DIV_W'(in_first);
                state_next       = srra_pkg::ST_LD_DIV1;
              end
            end
            srra_pkg::CMD_DRAIN: begin
              if (!sorted_done && order_bend) begin
                state_next = srra_pkg::ST_SO_I;
              end else begin
                state_next = srra_pkg::ST_DR_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      srra_pkg::ST_LD_DIV1: begin
        if (!div_rsp.busy) begin
          div_req.start    = 1'b1;
          div_req.dividend = srra_pkg::DIV_W'(ld_last);
          state_next       = srra_pkg::ST_LD_DIV2;
        end
      end
      srra_pkg::ST_LD_DIV2: begin
        if (!div_rsp.busy) begin
          state_next = srra_pkg::ST_LD_ST1;
        end
      end
      srra_pkg::ST_LD_ST1, srra_pkg::ST_LD_ST2: begin
        if (st_want && st_in_range && !st_full) begin
          ram_we    = 1'b1;
          ram_waddr = addr_of(st_r, fill[st_r][IDXW-1:0]);
          ram_wdata = {ld_id, ld_bend};
        end
        state_next = (state == srra_pkg::ST_LD_ST1) ? srra_pkg::ST_LD_ST2
                                                    : srra_pkg::ST_IDLE;
      end
      srra_pkg::ST_SO_I: begin
        if (!sreg_ok) begin
          state_next = srra_pkg::ST_DR_SCAN;
        end else if (si < fill[sreg_r]) begin
          ram_re     = 1'b1;
          ram_raddr  = addr_of(sreg_r, si[IDXW-1:0]);
          state_next = srra_pkg::ST_SO_LD;
        end
      end
      srra_pkg::ST_SO_LD: begin
        ram_re     = 1'b1;
        ram_raddr  = addr_of(sreg_r, si[IDXW-1:0] - 1'b1);
        state_next = srra_pkg::ST_SO_CMP;
      end
      srra_pkg::ST_SO_CMP: begin
        if (moves) begin
          ram_we    = 1'b1;
          ram_waddr = addr_of(sreg_r, sj[IDXW-1:0]);
          ram_wdata = ram_rdata;
          if (sj > FW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = addr_of(sreg_r, sj[IDXW-1:0] - IDXW'(2));
          end else begin
            state_next = srra_pkg::ST_SO_PUT;
          end
        end else begin
          state_next = srra_pkg::ST_SO_PUT;
        end
      end
      srra_pkg::ST_SO_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = addr_of(sreg_r, sj[IDXW-1:0]);
        ram_wdata  = hold;
        state_next = srra_pkg::ST_SO_I;
      end
      srra_pkg::ST_DR_SCAN: begin
        if (!dreg_ok) begin
          state_next = srra_pkg::ST_IDLE;
        end else if (didx < fill[dreg_r]) begin
          ram_re           = 1'b1;
          ram_raddr        = addr_of(dreg_r, didx[IDXW-1:0]);
          div_req.start    = 1'b1;
          div_req.dividend = srra_pkg::DIV_W'(didx);
          div_req.divisor  = lpr_eff;
          state_next       = srra_pkg::ST_DR_WAIT;
        end
      end
      srra_pkg::ST_DR_WAIT: begin
        if (!div_rsp.busy && out_free) begin
          state_next = srra_pkg::ST_IDLE;
        end
      end
      default: state_next = srra_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // event control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_REGIONS; k++) fill[k] <= '0;
      dreg          <= '0;
      didx          <= '0;
      sorted_done   <= 1'b0;
      overflow_seen <= 1'b0;
      sreg          <= '0;
      si            <= '0;
      sj            <= '0;
    end else begin
      case (state)
        srra_pkg::ST_IDLE: begin
          if (s_tvalid && in_cmd == srra_pkg::CMD_CLEAR) begin
            for (int k = 0; k < MAX_REGIONS; k++) fill[k] <= '0;
            dreg          <= '0;
            didx          <= '0;
            sorted_done   <= 1'b0;
            overflow_seen <= 1'b0;
          end else if (s_tvalid && in_cmd == srra_pkg::CMD_DRAIN && !sorted_done) begin
            sorted_done <= 1'b1;
            sreg        <= '0;
            si          <= FW'(1);
          end
        end
        srra_pkg::ST_LD_ST1, srra_pkg::ST_LD_ST2: begin
          if (st_want && st_in_range) begin
            if (st_full) begin
              overflow_seen <= 1'b1;
            end else begin
              fill[st_r] <= fill[st_r] + 1'b1;
            end
          end
        end
        srra_pkg::ST_SO_I: begin
          if (sreg_ok && !(si < fill[sreg_r])) begin
            sreg <= sreg + 1'b1;
            si   <= FW'(1);
          end
        end
        srra_pkg::ST_SO_LD: begin
          sj <= si;
        end
        srra_pkg::ST_SO_CMP: begin
          if (moves) sj <= sj - 1'b1;
        end
        srra_pkg::ST_SO_PUT: begin
          si <= si + 1'b1;
        end
        srra_pkg::ST_DR_SCAN: begin
          if (dreg_ok && !(didx < fill[dreg_r])) begin
            dreg <= dreg + 1'b1;
            didx <= '0;
          end
        end
        srra_pkg::ST_DR_WAIT: begin
          if (state_next == srra_pkg::ST_IDLE) didx <= didx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload captures
  always_ff @(posedge clk) begin
    if (state == srra_pkg::ST_IDLE && s_tvalid) begin
      ld_id   <= in_id;
      ld_bend <= in_bend;
      ld_last <= in_last;
    end
    if (state == srra_pkg::ST_LD_DIV1 && !div_rsp.busy) begin
      r1q <= div_rsp.quot;
    end
    if (state == srra_pkg::ST_SO_LD) begin
      hold <= ram_rdata;
    end
    if (state == srra_pkg::ST_DR_SCAN) begin
      drain_last <= !((didx + 1'b1) < fill[dreg_r]) && !later_any;
    end
  end

  // output register
  logic [9:0] link_full;
  assign link_full = 10'(dreg) * 10'(lpr_eff) + 10'(div_rsp.rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == srra_pkg::ST_DR_WAIT && state_next == srra_pkg::ST_IDLE) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == srra_pkg::ST_DR_WAIT && state_next == srra_pkg::ST_IDLE) begin
      m_tdata <= {6'd0, div_rsp.quot[7:0], link_full, 4'(dreg),
                  ram_rdata[DW-1:srra_pkg::BEND_W]};
      m_tlast <= drain_last;
      m_tuser <= overflow_seen;
    end
  end

  // checks
  logic fill_ok;
  always_comb begin
    fill_ok = 1'b1;
    for (int k = 0; k < MAX_REGIONS; k++) begin
      if (fill[k] > FW'(MAX_PER_REGION)) fill_ok = 1'b0;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill_ok)
    else $error("region fill beyond buffer size");

  a_no_load_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == srra_pkg::ST_LD_ST1 || state == srra_pkg::ST_LD_ST2) |-> !sorted_done)
    else $error("stub stored after draining began");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

endmodule

[hdl/srra_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srra_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module srra_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 2304
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/srra_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srra_div
// Restoring divider, one quotient bit per cycle, results held until next start.
// ----------------------------------------------------------------------------
module srra_div (
  input  logic               clk,
  input  logic               rst,
  input  srra_pkg::div_req_t req,
  output srra_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(srra_pkg::DIV_W + 1);

  logic [CW-1:0]                cnt;
  logic                         busy;
  logic [srra_pkg::DIV_W-1:0]   quot;
  logic [srra_pkg::DSR_W-1:0]   rem;
  logic [srra_pkg::DSR_W-1:0]   dsr;
  logic [srra_pkg::DSR_W:0]     trial;
  logic                         qbit;
  logic [srra_pkg::DSR_W:0]     diff;

  // one restoring step
  always_comb begin
    trial = {rem, quot[srra_pkg::DIV_W-1]};
    qbit  = (trial >= {1'b0, dsr});
    diff  = qbit ? (trial - {1'b0, dsr}) : trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CW'(srra_pkg::DIV_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem  <= '0;
      dsr  <= req.divisor;
    end else if (busy) begin
      quot <= {quot[srra_pkg::DIV_W-2:0], qbit};
      rem  <= diff[srra_pkg::DSR_W-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stub region round-robin assigner: a directed
// table of stubs and drains, then random events under several register
// settings, checked item by item against a behavioral model of the buffers.
// ----------------------------------------------------------------------------
module tb;

  localparam int NREG_MAX   = 9;
  localparam int DEPTH      = 256;
  localparam int RAND_ITEMS = 1100;
  localparam int IDLE_LIMIT = 200000;
  localparam int SETTLE     = 300;
  localparam int FLOOD_LOADS = 270;

  typedef struct packed {
    logic [11:0] stub;
    logic [3:0]  region;
    logic [9:0]  link;
    logic [7:0]  position;
    logic        last;
    logic        ovf;
  } assign_t;

  typedef struct {
    srra_pkg::cmd_t cmd;
    logic [11:0]    id;
    logic           pass;
    logic [9:0]     first;
    logic [9:0]     last;
    logic [4:0]     bend;
    bit             typed;
    bit             has_res;
    assign_t        res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  // model state
  logic [3:0]  m_nreg = srra_pkg::NUM_REGIONS_RST;
  logic [6:0]  m_spr  = srra_pkg::SPR_RST;
  logic [6:0]  m_lpr  = srra_pkg::LPR_RST;
  logic        m_obb  = srra_pkg::OBB_RST;
  logic [11:0] stub_mem [NREG_MAX][DEPTH];
  logic [4:0]  bend_mem [NREG_MAX][DEPTH];
  int          fill [NREG_MAX];
  int          drain_r, drain_i;
  bit          sorted, ovf_seen;

  assign_t     pending_q[$];
  row_t        dir_rows[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;

  stub_region_round_robin_assigner_core u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  function automatic int regions_used();
    return (m_nreg > NREG_MAX) ? NREG_MAX : int'(m_nreg);
  endfunction

  function automatic int mag(logic [4:0] b);
    return b[4] ? 32 - int'(b) : int'(b);
  endfunction

  function automatic void clear_event();
    foreach (fill[r]) fill[r] = 0;
    drain_r = 0;
    drain_i = 0;
    sorted = 1'b0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void put_stub(int r, logic [11:0] id, logic [4:0] bend);
    if (r >= regions_used()) return;
    if (fill[r] >= DEPTH) begin
      ovf_seen = 1'b1;
      return;
    end
    stub_mem[r][fill[r]] = id;
    bend_mem[r][fill[r]] = bend;
    fill[r]++;
  endfunction

  // stable insertion sort by bend magnitude
  function automatic void order_region(int r);
    logic [11:0] s;
    logic [4:0]  b;
    int          j;
    for (int i = 1; i < fill[r]; i++) begin
      s = stub_mem[r][i];
      b = bend_mem[r][i];
      j = i;
      while (j > 0 && mag(bend_mem[r][j-1]) > mag(b)) begin
        stub_mem[r][j] = stub_mem[r][j-1];
        bend_mem[r][j] = bend_mem[r][j-1];
        j--;
      end
      stub_mem[r][j] = s;
      bend_mem[r][j] = b;
    end
  endfunction

  // returns 1 and the next assignment when the item yields one
  function automatic bit predict_assign(row_t it, output assign_t res);
    int spr, lpr, nr, r1, r2;
    res = '0;
    nr = regions_used();
    case (it.cmd)
      srra_pkg::CMD_LOAD: begin
        spr = (m_spr == 0) ? 1 : int'(m_spr);
        if (!it.pass || sorted) return 0;
        r1 = int'(it.first) / spr;
        r2 = int'(it.last) / spr;
        put_stub(r1, it.id, it.bend);
        if (r2 != r1) put_stub(r2, it.id, it.bend);
        return 0;
      end
      srra_pkg::CMD_CLEAR: begin
        clear_event();
        return 0;
      end
      srra_pkg::CMD_DRAIN: begin
        lpr = (m_lpr == 0) ? 1 : int'(m_lpr);
        if (!sorted) begin
          if (m_obb) for (int r = 0; r < nr; r++) order_region(r);
          sorted = 1'b1;
        end
        while (drain_r < nr && drain_i >= fill[drain_r]) begin
          drain_r++;
          drain_i = 0;
        end
        if (drain_r >= nr) return 0;
        res.stub = stub_mem[drain_r][drain_i];
        res.region = drain_r[3:0];
        res.link = 10'(drain_r * lpr + drain_i % lpr);
        res.position = 8'(drain_i / lpr);
        res.last = 1'b1;
        if (drain_i + 1 < fill[drain_r]) res.last = 1'b0;
        for (int k = drain_r + 1; k < nr; k++) if (fill[k] > 0) res.last = 1'b0;
        res.ovf = ovf_seen;
        drain_i++;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // drive one item, hold it until accepted, then predict
  task automatic send_item(row_t it);
    assign_t res;
    if (!calm && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.cmd;
    s_tdata <= {2'b00, it.bend, it.last, it.first, it.pass, it.id};
    do @(posedge clk); while (!s_tready);
    if (predict_assign(it, res) && !it.typed) pending_q = {pending_q, res};
    if (it.typed && it.has_res) pending_q = {pending_q, it.res};
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(srra_pkg::reg_idx_t idx, logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      srra_pkg::REG_NUM_REGIONS: m_nreg = val[3:0];
      srra_pkg::REG_SPR:         m_spr = val;
      srra_pkg::REG_LPR:         m_lpr = val;
      default:                   m_obb = val[0];
    endcase
  endtask

  task automatic set_regs(logic [3:0] nr, logic [6:0] spr, logic [6:0] lpr, logic obb);
    settle();
    write_reg(srra_pkg::REG_NUM_REGIONS, {3'b000, nr});
    write_reg(srra_pkg::REG_SPR, spr);
    write_reg(srra_pkg::REG_LPR, lpr);
    write_reg(srra_pkg::REG_ORDER_BEND, {6'b0, obb});
    cfg_we <= 1'b0;
  endtask

  function automatic row_t mk(srra_pkg::cmd_t c, logic [11:0] id, logic p, logic [9:0] f,
                              logic [9:0] l, logic [4:0] b);
    row_t it;
    it.cmd = c; it.id = id; it.pass = p; it.first = f; it.last = l; it.bend = b;
    it.typed = 0; it.has_res = 0; it.res = '0;
    return it;
  endfunction

  function automatic void add_row(row_t it);
    dir_rows = {dir_rows, it};
  endfunction

  function automatic void add_typed(row_t it, bit has, assign_t r);
    it.typed = 1;
    it.has_res = has;
    it.res = r;
    add_row(it);
  endfunction

  // random stub whose sectors mostly fall in the regions in use
  function automatic row_t rand_stub(bit force_pass);
    int spr, span, f, l;
    spr = (m_spr == 0) ? 1 : int'(m_spr);
    span = regions_used() * spr + spr - 1;
    if (span > 1023) span = 1023;
    f = ($urandom_range(99) < 85) ? $urandom_range(0, span) : $urandom_range(0, 1023);
    case ($urandom_range(0, 19))
      0, 1, 2: l = $urandom_range(0, 1023);
      3, 4, 5, 6, 7: l = f + $urandom_range(0, 2 * spr);
      default: l = f;
    endcase
    if (l > 1023) l = 1023;
    return mk(srra_pkg::CMD_LOAD, 12'($urandom), force_pass || ($urandom_range(99) < 90),
              10'(f), 10'(l), 5'($urandom));
  endfunction

  // one event: clear, loads, then drains until empty with some noise
  task automatic run_event(inout int items, input int nloads);
    int ndrain;
    send_item(mk(srra_pkg::CMD_CLEAR, 12'($urandom), 1'b0, 10'd0, 10'd0, 5'd0));
    items++;
    for (int i = 0; i < nloads; i++) begin
      if ($urandom_range(99) < 3) begin
        send_item(mk(srra_pkg::CMD_UNUSED, 12'($urandom), 1'($urandom), 10'($urandom),
                     10'($urandom), 5'($urandom)));
        items++;
      end
      send_item(rand_stub(0));
      items++;
    end
    ndrain = 0;
    foreach (fill[r]) ndrain += fill[r];
    ndrain += $urandom_range(0, 2);
    for (int i = 0; i < ndrain; i++) begin
      if ($urandom_range(99) < 5) begin
        send_item(rand_stub(1));
        items++;
      end
      send_item(mk(srra_pkg::CMD_DRAIN, 12'($urandom), 1'($urandom), 10'($urandom),
                   10'($urandom), 5'($urandom)));
      items++;
    end
  endtask

  // output checker and watchdog
  always @(posedge clk) begin
    assign_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        if (pending_q.size() == 0) begin
          $display("%0t unexpected assignment stub=%0d region=%0d", $time,
                   m_tdata[11:0], m_tdata[15:12]);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (m_tdata[11:0] !== want.stub) begin
            $display("%0t stub exp %0d got %0d", $time, want.stub, m_tdata[11:0]);
            errors++;
          end
          if (m_tdata[15:12] !== want.region) begin
            $display("%0t region exp %0d got %0d", $time, want.region, m_tdata[15:12]);
            errors++;
          end
          if (m_tdata[25:16] !== want.link) begin
            $display("%0t link exp %0d got %0d", $time, want.link, m_tdata[25:16]);
            errors++;
          end
          if (m_tdata[33:26] !== want.position) begin
            $display("%0t position exp %0d got %0d", $time, want.position, m_tdata[33:26]);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t last exp %0b got %0b", $time, want.last, m_tlast);
            errors++;
          end
          if (m_tuser !== want.ovf) begin
            $display("%0t overflow exp %0b got %0b", $time, want.ovf, m_tuser);
            errors++;
          end
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 24);
  end

  initial begin
    int items;
    int nl;
    clear_event();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at the reset register values
    add_row(mk(srra_pkg::CMD_LOAD, 12'hFFF, 1'b1, 10'd0, 10'd0, 5'h10));
    add_row(mk(srra_pkg::CMD_LOAD, 12'h000, 1'b1, 10'd1, 10'd2, 5'h0F));
    add_row(mk(srra_pkg::CMD_LOAD, 12'h005, 1'b0, 10'd4, 10'd4, 5'h03));
    add_row(mk(srra_pkg::CMD_LOAD, 12'h3C3, 1'b1, 10'd1023, 10'd1023, 5'h01));
    add_row(mk(srra_pkg::CMD_LOAD, 12'hABC, 1'b1, 10'd17, 10'd3, 5'h00));
    add_row(mk(srra_pkg::CMD_UNUSED, 12'hFFF, 1'b1, 10'd0, 10'd0, 5'h1F));
    add_typed(mk(srra_pkg::CMD_DRAIN, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0), 1,
              '{12'h000, 4'd0, 10'd0, 8'd0, 1'b0, 1'b0});
    add_typed(mk(srra_pkg::CMD_DRAIN, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0), 1,
              '{12'hFFF, 4'd0, 10'd1, 8'd0, 1'b0, 1'b0});
    // loads are ignored once draining has begun
    add_row(mk(srra_pkg::CMD_LOAD, 12'h123, 1'b1, 10'd0, 10'd0, 5'h00));
    add_typed(mk(srra_pkg::CMD_DRAIN, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0), 1,
              '{12'hABC, 4'd1, 10'd24, 8'd0, 1'b0, 1'b0});
    add_typed(mk(srra_pkg::CMD_DRAIN, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0), 1,
              '{12'h000, 4'd1, 10'd25, 8'd0, 1'b0, 1'b0});
    add_typed(mk(srra_pkg::CMD_DRAIN, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0), 1,
              '{12'hABC, 4'd8, 10'd192, 8'd0, 1'b1, 1'b0});
    add_typed(mk(srra_pkg::CMD_DRAIN, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0), 0, '0);
    add_row(mk(srra_pkg::CMD_CLEAR, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0));
    add_row(mk(srra_pkg::CMD_LOAD, 12'h555, 1'b1, 10'd1023, 10'd0, 5'h0A));
    add_row(mk(srra_pkg::CMD_LOAD, 12'hAAA, 1'b1, 10'd682, 10'd341, 5'h15));
    add_row(mk(srra_pkg::CMD_LOAD, 12'h0F0, 1'b1, 10'd16, 10'd17, 5'h1F));
    add_row(mk(srra_pkg::CMD_DRAIN, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0));
    add_row(mk(srra_pkg::CMD_DRAIN, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0));
    add_row(mk(srra_pkg::CMD_DRAIN, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0));
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // register sweep, extremes first
    items = 0;
    set_regs(4'd1, 7'd64, 7'd1, 1'b0);
    while (items < 120) run_event(items, $urandom_range(0, 20));
    calm = 1'b1;
    set_regs(4'd15, 7'd1, 7'd64, 1'b1);
    while (items < 240) run_event(items, $urandom_range(0, 20));
    calm = 1'b0;
    set_regs(4'd9, 7'd0, 7'd0, 1'b1);
    while (items < 340) run_event(items, $urandom_range(0, 20));
    set_regs(4'd0, 7'd5, 7'd3, 1'b1);
    while (items < 370) run_event(items, $urandom_range(0, 10));
    // full buffer: region 0 flooded past its depth
    set_regs(4'd9, 7'd127, 7'd1, 1'b1);
    send_item(mk(srra_pkg::CMD_CLEAR, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0));
    items++;
    for (int i = 0; i < FLOOD_LOADS; i++) begin
      send_item(mk(srra_pkg::CMD_LOAD, 12'($urandom), 1'b1, 10'($urandom_range(0, 126)),
                   10'($urandom_range(0, 126)), 5'($urandom)));
      items++;
    end
    for (int i = 0; i < DEPTH + 2; i++) begin
      send_item(mk(srra_pkg::CMD_DRAIN, 12'h0, 1'b0, 10'd0, 10'd0, 5'h0));
      items++;
    end
    while (items < RAND_ITEMS) begin
      set_regs(4'($urandom_range(1, 15)), 7'($urandom_range(0, 127)),
               7'($urandom_range(0, 127)), 1'($urandom));
      nl = items + 120;
      while (items < nl) run_event(items, $urandom_range(0, 24));
    end

    settle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
